/* design/vrru_pkg.sv */
// Package for the vector reciprocal ROM unit: payload types, opcodes and the reciprocal ROM.
package vrru_pkg;

	localparam int LANE_COUNT = 8;
	localparam int LANE_BITS  = $clog2(LANE_COUNT);

	localparam logic OP_RCP_LOW  = 1'b0;
	localparam logic OP_RCP_HIGH = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [3:0]  source_select;
		logic [4:0]  dest_select;
		logic [15:0] lane_0;
		logic [15:0] lane_1;
		logic [15:0] lane_2;
		logic [15:0] lane_3;
		logic [15:0] lane_4;
		logic [15:0] lane_5;
		logic [15:0] lane_6;
		logic [15:0] lane_7;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  dest_lane;
		logic [15:0] dest_value;
		logic [15:0] high_result;
	} out_item_t;

	localparam logic [15:0] RECIP_ROM [512] = '{
16'hffff,16'hff00,16'hfe01,16'hfd04,16'hfc07,16'hfb0c,16'hfa11,16'hf918,
16'hf81f,16'hf727,16'hf631,16'hf53b,16'hf446,16'hf352,16'hf25f,16'hf16d,
16'hf07c,16'hef8b,16'hee9c,16'hedae,16'hecc0,16'hebd3,16'heae8,16'he9fd,
16'he913,16'he829,16'he741,16'he65a,16'he573,16'he48d,16'he3a9,16'he2c5,
16'he1e1,16'he0ff,16'he01e,16'hdf3d,16'hde5d,16'hdd7e,16'hdca0,16'hdbc2,
16'hdae6,16'hda0a,16'hd92f,16'hd854,16'hd77b,16'hd6a2,16'hd5ca,16'hd4f3,
16'hd41d,16'hd347,16'hd272,16'hd19e,16'hd0cb,16'hcff8,16'hcf26,16'hce55,
16'hcd85,16'hccb5,16'hcbe6,16'hcb18,16'hca4b,16'hc97e,16'hc8b2,16'hc7e7,
16'hc71c,16'hc652,16'hc589,16'hc4c0,16'hc3f8,16'hc331,16'hc26b,16'hc1a5,
16'hc0e0,16'hc01c,16'hbf58,16'hbe95,16'hbdd2,16'hbd10,16'hbc4f,16'hbb8f,
16'hbacf,16'hba10,16'hb951,16'hb894,16'hb7d6,16'hb71a,16'hb65e,16'hb5a2,
16'hb4e8,16'hb42e,16'hb374,16'hb2bb,16'hb203,16'hb14b,16'hb094,16'hafde,
16'haf28,16'hae73,16'hadbe,16'had0a,16'hac57,16'haba4,16'haaf1,16'haa40,
16'ha98e,16'ha8de,16'ha82e,16'ha77e,16'ha6d0,16'ha621,16'ha574,16'ha4c6,
16'ha41a,16'ha36e,16'ha2c2,16'ha217,16'ha16d,16'ha0c3,16'ha01a,16'h9f71,
16'h9ec8,16'h9e21,16'h9d79,16'h9cd3,16'h9c2d,16'h9b87,16'h9ae2,16'h9a3d,
16'h9999,16'h98f6,16'h9852,16'h97b0,16'h970e,16'h966c,16'h95cb,16'h952b,
16'h948b,16'h93eb,16'h934c,16'h92ad,16'h920f,16'h9172,16'h90d4,16'h9038,
16'h8f9c,16'h8f00,16'h8e65,16'h8dca,16'h8d30,16'h8c96,16'h8bfc,16'h8b64,
16'h8acb,16'h8a33,16'h899c,16'h8904,16'h886e,16'h87d8,16'h8742,16'h86ad,
16'h8618,16'h8583,16'h84f0,16'h845c,16'h83c9,16'h8336,16'h82a4,16'h8212,
16'h8181,16'h80f0,16'h8060,16'h7fd0,16'h7f40,16'h7eb1,16'h7e22,16'h7d93,
16'h7d05,16'h7c78,16'h7beb,16'h7b5e,16'h7ad2,16'h7a46,16'h79ba,16'h792f,
16'h78a4,16'h781a,16'h7790,16'h7706,16'h767d,16'h75f5,16'h756c,16'h74e4,
16'h745d,16'h73d5,16'h734f,16'h72c8,16'h7242,16'h71bc,16'h7137,16'h70b2,
16'h702e,16'h6fa9,16'h6f26,16'h6ea2,16'h6e1f,16'h6d9c,16'h6d1a,16'h6c98,
16'h6c16,16'h6b95,16'h6b14,16'h6a94,16'h6a13,16'h6993,16'h6914,16'h6895,
16'h6816,16'h6798,16'h6719,16'h669c,16'h661e,16'h65a1,16'h6524,16'h64a8,
16'h642c,16'h63b0,16'h6335,16'h62ba,16'h623f,16'h61c5,16'h614b,16'h60d1,
16'h6058,16'h5fdf,16'h5f66,16'h5eed,16'h5e75,16'h5dfd,16'h5d86,16'h5d0f,
16'h5c98,16'h5c22,16'h5bab,16'h5b35,16'h5ac0,16'h5a4b,16'h59d6,16'h5961,
16'h58ed,16'h5879,16'h5805,16'h5791,16'h571e,16'h56ac,16'h5639,16'h55c7,
16'h5555,16'h54e3,16'h5472,16'h5401,16'h5390,16'h5320,16'h52af,16'h5240,
16'h51d0,16'h5161,16'h50f2,16'h5083,16'h5015,16'h4fa6,16'h4f38,16'h4ecb,
16'h4e5e,16'h4df1,16'h4d84,16'h4d17,16'h4cab,16'h4c3f,16'h4bd3,16'h4b68,
16'h4afd,16'h4a92,16'h4a27,16'h49bd,16'h4953,16'h48e9,16'h4880,16'h4817,
16'h47ae,16'h4745,16'h46dc,16'h4674,16'h460c,16'h45a5,16'h453d,16'h44d6,
16'h446f,16'h4408,16'h43a2,16'h433c,16'h42d6,16'h4270,16'h420b,16'h41a6,
16'h4141,16'h40dc,16'h4078,16'h4014,16'h3fb0,16'h3f4c,16'h3ee8,16'h3e85,
16'h3e22,16'h3dc0,16'h3d5d,16'h3cfb,16'h3c99,16'h3c37,16'h3bd6,16'h3b74,
16'h3b13,16'h3ab2,16'h3a52,16'h39f1,16'h3991,16'h3931,16'h38d2,16'h3872,
16'h3813,16'h37b4,16'h3755,16'h36f7,16'h3698,16'h363a,16'h35dc,16'h357f,
16'h3521,16'h34c4,16'h3467,16'h340a,16'h33ae,16'h3351,16'h32f5,16'h3299,
16'h323e,16'h31e2,16'h3187,16'h312c,16'h30d1,16'h3076,16'h301c,16'h2fc2,
16'h2f68,16'h2f0e,16'h2eb4,16'h2e5b,16'h2e02,16'h2da9,16'h2d50,16'h2cf8,
16'h2c9f,16'h2c47,16'h2bef,16'h2b97,16'h2b40,16'h2ae8,16'h2a91,16'h2a3a,
16'h29e4,16'h298d,16'h2937,16'h28e0,16'h288b,16'h2835,16'h27df,16'h278a,
16'h2735,16'h26e0,16'h268b,16'h2636,16'h25e2,16'h258d,16'h2539,16'h24e5,
16'h2492,16'h243e,16'h23eb,16'h2398,16'h2345,16'h22f2,16'h22a0,16'h224d,
16'h21fb,16'h21a9,16'h2157,16'h2105,16'h20b4,16'h2063,16'h2012,16'h1fc1,
16'h1f70,16'h1f1f,16'h1ecf,16'h1e7f,16'h1e2e,16'h1ddf,16'h1d8f,16'h1d3f,
16'h1cf0,16'h1ca1,16'h1c52,16'h1c03,16'h1bb4,16'h1b66,16'h1b17,16'h1ac9,
16'h1a7b,16'h1a2d,16'h19e0,16'h1992,16'h1945,16'h18f8,16'h18ab,16'h185e,
16'h1811,16'h17c4,16'h1778,16'h172c,16'h16e0,16'h1694,16'h1648,16'h15fd,
16'h15b1,16'h1566,16'h151b,16'h14d0,16'h1485,16'h143b,16'h13f0,16'h13a6,
16'h135c,16'h1312,16'h12c8,16'h127f,16'h1235,16'h11ec,16'h11a3,16'h1159,
16'h1111,16'h10c8,16'h107f,16'h1037,16'h0fef,16'h0fa6,16'h0f5e,16'h0f17,
16'h0ecf,16'h0e87,16'h0e40,16'h0df9,16'h0db2,16'h0d6b,16'h0d24,16'h0cdd,
16'h0c97,16'h0c50,16'h0c0a,16'h0bc4,16'h0b7e,16'h0b38,16'h0af2,16'h0aad,
16'h0a68,16'h0a22,16'h09dd,16'h0998,16'h0953,16'h090f,16'h08ca,16'h0886,
16'h0842,16'h07fd,16'h07b9,16'h0776,16'h0732,16'h06ee,16'h06ab,16'h0668,
16'h0624,16'h05e1,16'h059e,16'h055c,16'h0519,16'h04d6,16'h0494,16'h0452,
16'h0410,16'h03ce,16'h038c,16'h034a,16'h0309,16'h02c7,16'h0286,16'h0245,
16'h0204,16'h01c3,16'h0182,16'h0141,16'h0101,16'h00c0,16'h0080,16'h0040
	};

endpackage

/* design/vector_reciprocal_rom_unit.sv */
// Vector reciprocal ROM unit: input register, one-pass reciprocal, result register.
// An accepted item moves into the result register when that is empty or out_ready is high.
// Throughput: one item per cycle while out_ready is high; the reciprocal (leading-zero
// count, ROM read, shift) sits in the single logic stage between the two registers.
// Reset (arst_n low, asynchronous): both stages empty, pending high input and
// stored high result cleared to zero.
module vector_reciprocal_rom_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vrru_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vrru_pkg::out_item_t out_data
);
	import vrru_pkg::*;

	logic           valid_s1;
	in_item_t       item_s1;
	logic           valid_s2;
	out_item_t      item_s2;
	logic [15:0]    pending_q;
	logic [15:0]    stored_q;

	logic           adv_s1;
	logic [3:0]     top_bit;
	logic [3:0]     sel_mask;
	logic [LANE_BITS-1:0] src_idx;
	logic [15:0]    lanes [LANE_COUNT];
	logic [15:0]    src_lane;
	logic [31:0]    operand;
	logic           negative;
	logic [31:0]    magnitude;
	logic [4:0]     lead_zeros;
	logic [31:0]    normalized;
	logic [8:0]     rom_idx;
	logic [31:0]    mantissa;
	logic [31:0]    recip;
	logic [31:0]    result;
	out_item_t      next_item;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_comb begin
		top_bit = 4'd0;
		for (int b = 0; b < 4; b++) begin
			if (item_s1.source_select[b]) begin
				top_bit = 4'(b);
			end
		end
	end

	assign sel_mask = 4'(4'hF << top_bit);
	assign src_idx  = LANE_BITS'((item_s1.dest_select[3:0] & sel_mask)
		| (item_s1.source_select & ~sel_mask));

	assign lanes[0] = item_s1.lane_0;
	assign lanes[1] = item_s1.lane_1;
	assign lanes[2] = item_s1.lane_2;
	assign lanes[3] = item_s1.lane_3;
	assign lanes[4] = item_s1.lane_4;
	assign lanes[5] = item_s1.lane_5;
	assign lanes[6] = item_s1.lane_6;
	assign lanes[7] = item_s1.lane_7;
	assign src_lane = lanes[src_idx];

	assign operand   = {pending_q, src_lane};
	assign negative  = operand[31];
	assign magnitude = negative ? (32'd0 - operand) : operand;

	always_comb begin
		lead_zeros = 5'd0;
		for (int b = 0; b < 32; b++) begin
			if (magnitude[b]) begin
				lead_zeros = 5'(31 - b);
			end
		end
	end

	assign normalized = magnitude << lead_zeros;
	assign rom_idx    = normalized[30:22];
	assign mantissa   = {1'b0, 1'b1, RECIP_ROM[rom_idx], 14'd0};
	assign recip      = mantissa >> (5'd31 - lead_zeros);
	assign result     = (operand == 32'd0) ? 32'hFFFF_FFFF : (negative ? ~recip : recip);

	always_comb begin
		next_item.dest_lane = item_s1.dest_select[2:0];
		case (item_s1.operation)
			OP_RCP_HIGH: begin
				next_item.dest_value  = stored_q;
				next_item.high_result = stored_q;
			end
			default: begin
				next_item.dest_value  = result[15:0];
				next_item.high_result = result[31:16];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			pending_q <= 16'd0;
			stored_q  <= 16'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				if (item_s1.operation == OP_RCP_HIGH) begin
					pending_q <= src_lane;
				end else begin
					pending_q <= 16'd0;
					stored_q  <= result[31:16];
				end
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			item_s2 <= next_item;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = item_s2;

endmodule

/* design/vrru_checker.sv */
// Port-level checker for the vector reciprocal ROM unit and its bind.
module vrru_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input vrru_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input vrru_pkg::out_item_t out_data
);
	import vrru_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input transfer changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

	a_accept_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted transfer produced no result");

endmodule

bind vector_reciprocal_rom_unit vrru_checker u_vrru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/tb_vector_reciprocal_rom_unit.sv */
// Testbench for vector_reciprocal_rom_unit: directed table and random instruction stream against a predictor.
`timescale 1ns / 100ps

module tb_vector_reciprocal_rom_unit;
	import vrru_pkg::*;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} stim_row_t;

	localparam int DIR_ROWS = 24;
	localparam int PHASE_ITEMS = 325;
	localparam logic [127:0] SPREAD = {16'h0001, 16'h0123, 16'h0fed, 16'h7fff,
		16'h8000, 16'ha5a5, 16'hfffe, 16'h4000};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	logic [15:0] model_pend_hi = '0;
	logic [15:0] model_stored_hi = '0;
	out_item_t   predicted_writes [$];
	stim_row_t   directed [DIR_ROWS];

	int send_idle = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int n_low = 0;
	int n_high = 0;
	int n_zero = 0;
	int n_neg = 0;
	int n_checked = 0;

	vector_reciprocal_rom_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("tb_vector_reciprocal_rom_unit failed");
		$finish;
	end

	// Lane pick, 32-bit reciprocal and state update for one instruction.
	function automatic out_item_t predict_rcp(in_item_t it);
		logic [15:0] lanes [LANE_COUNT];
		logic [3:0]  mask;
		logic [2:0]  src;
		logic [15:0] lane;
		logic [31:0] opnd;
		logic [31:0] mag;
		logic [31:0] norm;
		logic [31:0] r;
		int          lz;
		out_item_t   res;
		lanes = '{it.lane_0, it.lane_1, it.lane_2, it.lane_3,
			it.lane_4, it.lane_5, it.lane_6, it.lane_7};
		mask = 4'hf;
		for (int b = 0; b < 4; b++) begin
			if (it.source_select[b]) begin
				mask = 4'hf << b;
			end
		end
		src = 3'((it.dest_select[3:0] & mask) | (it.source_select & ~mask));
		lane = lanes[src];
		res.dest_lane = it.dest_select[2:0];
		if (it.operation == OP_RCP_HIGH) begin
			n_high++;
			res.dest_value = model_stored_hi;
			model_pend_hi = lane;
		end else begin
			n_low++;
			opnd = {model_pend_hi, lane};
			if (opnd == '0) begin
				n_zero++;
				r = '1;
			end else begin
				mag = opnd[31] ? -opnd : opnd;
				lz = 0;
				while (!mag[31 - lz]) begin
					lz++;
				end
				norm = mag << lz;
				r = ({15'd0, 1'b1, RECIP_ROM[norm[30:22]]} << 14) >> (31 - lz);
				if (opnd[31]) begin
					n_neg++;
					r = ~r;
				end
			end
			res.dest_value = r[15:0];
			model_stored_hi = r[31:16];
			model_pend_hi = '0;
		end
		res.high_result = model_stored_hi;
		return res;
	endfunction

	function automatic stim_row_t dir_row(logic op, logic [3:0] ssel, logic [4:0] dsel,
			logic [127:0] lanes, logic typed, logic [15:0] val, logic [15:0] hi);
		stim_row_t r;
		r.item = {op, ssel, dsel, lanes};
		r.typed = typed;
		r.want = {dsel[2:0], val, hi};
		return r;
	endfunction

	// Mix of full-range values and values with many leading zeros.
	function automatic logic [15:0] rnd_lane();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(31))
			0: v = 16'h0000;
			1: v = 16'hffff;
			2: v = 16'h8000;
			default: begin
				if ($urandom_range(1)) begin
					v = v >> $urandom_range(15);
				end
			end
		endcase
		return v;
	endfunction

	function automatic in_item_t rnd_item(logic op);
		in_item_t it;
		it.operation = op;
		it.source_select = 4'($urandom);
		it.dest_select = 5'($urandom);
		it.lane_0 = rnd_lane();
		it.lane_1 = rnd_lane();
		it.lane_2 = rnd_lane();
		it.lane_3 = rnd_lane();
		it.lane_4 = rnd_lane();
		it.lane_5 = rnd_lane();
		it.lane_6 = rnd_lane();
		it.lane_7 = rnd_lane();
		return it;
	endfunction

	// Called at a rising edge; returns at the edge of the transfer.
	task automatic push_item(in_item_t it, logic typed, out_item_t want);
		out_item_t p;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		p = predict_rcp(it);
		predicted_writes.push_back(typed ? want : p);
	endtask

	always @(posedge clk) begin : result_mon
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result lane=%0d value=%h high=%h", $realtime,
						out_data.dest_lane, out_data.dest_value, out_data.high_result);
				end
			end else begin
				want = predicted_writes.pop_front();
				n_checked++;
				if (out_data.dest_lane !== want.dest_lane
						|| out_data.dest_value !== want.dest_value
						|| out_data.high_result !== want.high_result) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch lane exp %0d got %0d, value exp %h got %h, high exp %h got %h",
							$realtime, want.dest_lane, out_data.dest_lane, want.dest_value,
							out_data.dest_value, want.high_result, out_data.high_result);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	initial begin
		int n;
		int kind;
		directed = '{
			dir_row(OP_RCP_LOW,  4'h0, 5'h00, {8{16'h0000}}, 1'b1, 16'hffff, 16'hffff),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h05, {8{16'h8000}}, 1'b1, 16'hffff, 16'hffff),
			dir_row(OP_RCP_LOW,  4'h0, 5'h1f, {8{16'h0000}}, 1'b1, 16'hffff, 16'hffff),
			dir_row(OP_RCP_LOW,  4'h0, 5'h08, {8{16'h0001}}, 1'b1, 16'hc000, 16'h7fff),
			dir_row(OP_RCP_HIGH, 4'hf, 5'h00, {8{16'hffff}}, 1'b1, 16'h7fff, 16'h7fff),
			dir_row(OP_RCP_LOW,  4'hf, 5'h00, {8{16'hffff}}, 1'b0, '0, '0),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h00, {8{16'h7fff}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h0, 5'h00, {8{16'hffff}}, 1'b0, '0, '0),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h02, {8{16'h8000}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h0, 5'h02, {8{16'h0001}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h0, 5'h04, {8{16'hffff}}, 1'b0, '0, '0),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h06, {8{16'h1234}}, 1'b0, '0, '0),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h06, {8{16'h0000}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h0, 5'h03, {8{16'h0000}}, 1'b1, 16'hffff, 16'hffff),
			dir_row(OP_RCP_HIGH, 4'h0, 5'h01, {8{16'h0040}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h0, 5'h01, {8{16'h0000}}, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h1, 5'h1f, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h2, 5'h15, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h4, 5'h0a, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h8, 5'h17, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_HIGH, 4'h3, 5'h1c, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h6, 5'h03, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'h5, 5'h1e, SPREAD, 1'b0, '0, '0),
			dir_row(OP_RCP_LOW,  4'hc, 5'h10, SPREAD, 1'b0, '0, '0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			push_item(directed[i].item, directed[i].typed, directed[i].want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 76; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 76; end
				default: begin send_idle = 29; recv_stall = 29; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				kind = $urandom_range(99);
				if (kind < 60) begin
					push_item(rnd_item(OP_RCP_HIGH), 1'b0, '0);
					push_item(rnd_item(OP_RCP_LOW), 1'b0, '0);
					n += 2;
				end else if (kind < 85) begin
					push_item(rnd_item(OP_RCP_LOW), 1'b0, '0);
					n++;
				end else begin
					push_item(rnd_item(OP_RCP_HIGH), 1'b0, '0);
					n++;
				end
			end
		end
		in_valid <= 1'b0;

		while (predicted_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("instructions: %0d low, %0d high; results checked: %0d",
			n_low, n_high, n_checked);
		$display("zero operands: %0d, negative operands: %0d, mismatches: %0d",
			n_zero, n_neg, mismatches);
		if (mismatches == 0) begin
			$display("tb_vector_reciprocal_rom_unit passed");
		end else begin
			$display("tb_vector_reciprocal_rom_unit failed");
		end
		$finish;
	end

endmodule

/* files.f */
design/vrru_pkg.sv
design/vector_reciprocal_rom_unit.sv
design/vrru_checker.sv
tb/tb_vector_reciprocal_rom_unit.sv
